[hw/rtl/ftmd_pkg.sv]
// Package: shared types and constants of the message deframer.
package ftmd_pkg;

    localparam int unsigned COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Opcodes
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_RRQ   = 4'd1;
    localparam logic [3:0] OP_WRQ   = 4'd2;
    localparam logic [3:0] OP_DATA  = 4'd3;
    localparam logic [3:0] OP_ACK   = 4'd4;
    localparam logic [3:0] OP_ERROR = 4'd5;
    localparam logic [3:0] OP_DIR   = 4'd6;
    localparam logic [3:0] OP_LOGIN = 4'd7;
    localparam logic [3:0] OP_MSG   = 4'd8;
    localparam logic [3:0] OP_BCAST = 4'd9;
    localparam logic [3:0] OP_DISC  = 4'd10;

    typedef enum logic [2:0] {
        KIND_START   = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_FLAG    = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_BAD     = 3'd4,
        KIND_TERM    = 3'd5
    } item_kind_t;

    typedef enum logic [2:0] {
        PH_HIGH = 3'b001,
        PH_LOW  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [7:0]         hold;
        logic [3:0]         opcode;
        logic [COUNT_W-1:0] count;
        logic [15:0]        size;
    } parse_state_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] opcode;
        item_kind_t kind;
        logic       slot;
        logic [15:0] value;
        logic       last;
    } result_t;

endpackage

[hw/rtl/ftmd_byte_if.sv]
// Interface: received byte channel.
interface ftmd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

[hw/rtl/ftmd_result_if.sv]
// Interface: deframer result channel.
interface ftmd_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  msg_opcode;
    logic [2:0]  item_kind;
    logic        field_slot;
    logic [15:0] value;
    logic        last;

    modport source (output valid, output msg_opcode, output item_kind, output field_slot,
                    output value, output last, input ready);
    modport sink (input valid, input msg_opcode, input item_kind, input field_slot,
                  input value, input last, output ready);
endinterface

[hw/rtl/ftmd_cfg_if.sv]
// Interface: terminator register write channel.
interface ftmd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] terminator_byte;

    modport source (output valid, output terminator_byte, input ready);
    modport sink (input valid, input terminator_byte, output ready);
endinterface

[hw/rtl/ftmd_step.sv]
// Combinational parse step: next parser state and result for one byte.
module ftmd_step (
    input  ftmd_pkg::parse_state_t state,
    input  logic [7:0]             byte_in,
    input  logic [7:0]             terminator,
    output ftmd_pkg::parse_state_t state_next,
    output ftmd_pkg::result_t      res
);

    logic [15:0]                    word;
    logic [ftmd_pkg::COUNT_W-1:0]   n;
    logic                           is_term;
    logic                           data_end;

    assign word     = {state.hold, byte_in};
    assign n        = state.count;
    assign is_term  = (byte_in == terminator);
    assign data_end = ((n - ftmd_pkg::COUNT_W'(3)) >= {1'b0, state.size});

    always_comb
    begin
        state_next = state;
        res        = '0;
        res.kind   = ftmd_pkg::KIND_START;
        unique case (state.phase)
            ftmd_pkg::PH_LOW:
            begin
                state_next.count = '0;
                res.valid        = 1'b1;
                if (word < 16'd1 || word > 16'(ftmd_pkg::OP_DISC))
                begin
                    state_next.opcode = ftmd_pkg::OP_NONE;
                    state_next.phase  = ftmd_pkg::PH_HIGH;
                    res.opcode        = ftmd_pkg::OP_NONE;
                    res.kind          = ftmd_pkg::KIND_BAD;
                    res.last          = 1'b1;
                end
                else
                begin
                    state_next.opcode = word[3:0];
                    res.opcode        = word[3:0];
                    if (word[3:0] == ftmd_pkg::OP_DIR || word[3:0] == ftmd_pkg::OP_DISC)
                    begin
                        state_next.phase = ftmd_pkg::PH_HIGH;
                        res.last         = 1'b1;
                    end
                    else
                    begin
                        state_next.phase = ftmd_pkg::PH_BODY;
                    end
                end
            end
            ftmd_pkg::PH_BODY:
            begin
                if (n != ftmd_pkg::COUNT_MAX)
                    state_next.count = n + 1'b1;
                res.opcode = state.opcode;
                unique case (state.opcode)
                    ftmd_pkg::OP_RRQ, ftmd_pkg::OP_WRQ, ftmd_pkg::OP_LOGIN, ftmd_pkg::OP_MSG:
                    begin
                        res.valid = 1'b1;
                        if (is_term)
                        begin
                            state_next.phase = ftmd_pkg::PH_HIGH;
                            state_next.count = '0;
                            res.kind         = ftmd_pkg::KIND_TERM;
                            res.last         = 1'b1;
                        end
                        else
                        begin
                            res.kind  = ftmd_pkg::KIND_PAYLOAD;
                            res.value = {8'd0, byte_in};
                        end
                    end
                    ftmd_pkg::OP_DATA:
                    begin
                        if (n == 'd0 || n == 'd2)
                        begin
                            state_next.hold = byte_in;
                        end
                        else if (n == 'd1)
                        begin
                            state_next.size = word;
                            res.valid       = 1'b1;
                            res.kind        = ftmd_pkg::KIND_HEADER;
                            res.value       = word;
                        end
                        else if (n == 'd3)
                        begin
                            res.valid = 1'b1;
                            res.kind  = ftmd_pkg::KIND_HEADER;
                            res.slot  = 1'b1;
                            res.value = word;
                            if (state.size == 16'd0)
                            begin
                                state_next.phase = ftmd_pkg::PH_HIGH;
                                state_next.count = '0;
                                res.last         = 1'b1;
                            end
                        end
                        else
                        begin
                            res.valid = 1'b1;
                            res.kind  = ftmd_pkg::KIND_PAYLOAD;
                            res.value = {8'd0, byte_in};
                            if (data_end)
                            begin
                                state_next.phase = ftmd_pkg::PH_HIGH;
                                state_next.count = '0;
                                res.last         = 1'b1;
                            end
                        end
                    end
                    ftmd_pkg::OP_ACK:
                    begin
                        if (n == 'd0)
                        begin
                            state_next.hold = byte_in;
                        end
                        else
                        begin
                            state_next.phase = ftmd_pkg::PH_HIGH;
                            state_next.count = '0;
                            res.valid        = 1'b1;
                            res.kind         = ftmd_pkg::KIND_HEADER;
                            res.value        = word;
                            res.last         = 1'b1;
                        end
                    end
                    ftmd_pkg::OP_ERROR:
                    begin
                        if (n == 'd0)
                        begin
                            state_next.hold = byte_in;
                        end
                        else if (n == 'd1)
                        begin
                            res.valid = 1'b1;
                            res.kind  = ftmd_pkg::KIND_HEADER;
                            res.value = word;
                        end
                        else
                        begin
                            res.valid = 1'b1;
                            if (is_term)
                            begin
                                state_next.phase = ftmd_pkg::PH_HIGH;
                                state_next.count = '0;
                                res.kind         = ftmd_pkg::KIND_TERM;
                                res.last         = 1'b1;
                            end
                            else
                            begin
                                res.kind  = ftmd_pkg::KIND_PAYLOAD;
                                res.value = {8'd0, byte_in};
                            end
                        end
                    end
                    ftmd_pkg::OP_BCAST:
                    begin
                        res.valid = 1'b1;
                        if (n == 'd0)
                        begin
                            res.kind  = ftmd_pkg::KIND_FLAG;
                            res.value = {8'd0, byte_in};
                        end
                        else if (is_term)
                        begin
                            state_next.phase = ftmd_pkg::PH_HIGH;
                            state_next.count = '0;
                            res.kind         = ftmd_pkg::KIND_TERM;
                            res.last         = 1'b1;
                        end
                        else
                        begin
                            res.kind  = ftmd_pkg::KIND_PAYLOAD;
                            res.value = {8'd0, byte_in};
                        end
                    end
                    default:
                    begin
                        // opcode without a body: drop the byte and resync
                        state_next.phase = ftmd_pkg::PH_HIGH;
                        state_next.count = '0;
                    end
                endcase
            end
            default:
            begin
                state_next.hold  = byte_in;
                state_next.phase = ftmd_pkg::PH_LOW;
            end
        endcase
    end

endmodule

[hw/rtl/file_transfer_message_deframer_core.sv]
// Top level: message deframer with input register, parse step and result register.
//
// Channel       Dir  Payload                                          Accepted when
// byte_stream   in   byte_in[7:0]                                     valid && ready
// result        out  msg_opcode, item_kind, field_slot, value, last   valid && ready
// cfg           in   terminator_byte[7:0]                             valid && ready
//
// One byte per cycle sustained while result is not stalled; an accepted byte is registered, then its result.
// The parse step sits between the input register and the result register.
// Bytes that give no result pass through without occupying the result register.
// rst_n clears parser state, terminator (to zero) and both valid flags.
// A stalled result holds both stages; byte_stream.ready drops once the input register is full.
module file_transfer_message_deframer_core (
    input  logic                 clk,
    input  logic                 rst_n,
    ftmd_byte_if.sink            byte_stream,
    ftmd_result_if.source        result,
    ftmd_cfg_if.sink             cfg
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    ftmd_pkg::result_t      out_res_reg;
    ftmd_pkg::parse_state_t state_reg;
    ftmd_pkg::parse_state_t state_next;
    ftmd_pkg::result_t      step_res;
    logic [7:0]             term_reg;
    logic                   advance;

    assign advance           = !out_valid_reg || result.ready;
    assign byte_stream.ready = !in_valid_reg || advance;
    assign cfg.ready         = 1'b1;

    ftmd_step u_step (
        .state      (state_reg),
        .byte_in    (in_byte_reg),
        .terminator (term_reg),
        .state_next (state_next),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= 8'd0;
        end
        else if (cfg.valid)
        begin
            term_reg <= cfg.terminator_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_stream.valid && byte_stream.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
            in_byte_reg <= byte_stream.byte_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: ftmd_pkg::PH_HIGH, hold: 8'd0, opcode: ftmd_pkg::OP_NONE,
                           count: '0, size: 16'd0};
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_valid_reg)
            begin
                state_reg     <= state_next;
                out_valid_reg <= step_res.valid;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_res_reg <= step_res;
    end

    assign result.valid      = out_valid_reg;
    assign result.msg_opcode = out_res_reg.opcode;
    assign result.item_kind  = out_res_reg.kind;
    assign result.field_slot = out_res_reg.slot;
    assign result.value      = out_res_reg.value;
    assign result.last       = out_res_reg.last;

endmodule

[dv/file_transfer_message_deframer_core_test.sv]
// Testbench: message deframer checked item by item against its own parse model.
module file_transfer_message_deframer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 600;

    typedef struct {
        logic [3:0]           opcode;
        ftmd_pkg::item_kind_t kind;
        logic                 slot;
        logic [15:0]          value;
        logic                 last;
    } frame_item_t;

    logic clk;
    logic rst_n;

    ftmd_byte_if   byte_if ();
    ftmd_result_if res_if ();
    ftmd_cfg_if    cfg_if ();

    file_transfer_message_deframer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .result      (res_if),
        .cfg         (cfg_if)
    );

    // parser copy
    ftmd_pkg::phase_t             ph;
    logic [7:0]                   hold_byte;
    logic [3:0]                   cur_op;
    logic [ftmd_pkg::COUNT_W-1:0] body_cnt;
    logic [15:0]                  size_word;
    logic [7:0]                   term_byte;

    frame_item_t pending_frames[$];

    int send_idle_pct;
    int take_idle_pct;
    int hold_off_request;
    int bytes_sent;
    int results_seen;
    int term_writes;
    int errors;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void end_msg();
        ph = ftmd_pkg::PH_HIGH;
        body_cnt = '0;
    endfunction

    function automatic bit string_byte(input logic [7:0] b, inout frame_item_t r);
        if (b == term_byte)
        begin
            end_msg();
            r.kind = ftmd_pkg::KIND_TERM;
            r.value = 16'h0;
            r.last = 1'b1;
        end
        else
        begin
            r.kind = ftmd_pkg::KIND_PAYLOAD;
            r.value = {8'h00, b};
        end
        return 1'b1;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output frame_item_t r);
        logic [15:0]                  word;
        logic [ftmd_pkg::COUNT_W-1:0] n;
        r = '{opcode: ftmd_pkg::OP_NONE, kind: ftmd_pkg::KIND_START, slot: 1'b0,
              value: 16'h0, last: 1'b0};
        if (ph != ftmd_pkg::PH_LOW && ph != ftmd_pkg::PH_BODY)
        begin
            hold_byte = b;
            ph = ftmd_pkg::PH_LOW;
            return 1'b0;
        end
        if (ph == ftmd_pkg::PH_LOW)
        begin
            word = {hold_byte, b};
            body_cnt = '0;
            if (word < 16'd1 || word > 16'(ftmd_pkg::OP_DISC))
            begin
                cur_op = ftmd_pkg::OP_NONE;
                ph = ftmd_pkg::PH_HIGH;
                r.kind = ftmd_pkg::KIND_BAD;
                r.last = 1'b1;
                return 1'b1;
            end
            cur_op = word[3:0];
            r.opcode = cur_op;
            if (cur_op == ftmd_pkg::OP_DIR || cur_op == ftmd_pkg::OP_DISC)
            begin
                ph = ftmd_pkg::PH_HIGH;
                r.last = 1'b1;
            end
            else
                ph = ftmd_pkg::PH_BODY;
            return 1'b1;
        end

        n = body_cnt;
        if (body_cnt != ftmd_pkg::COUNT_MAX)
            body_cnt = body_cnt + 1'b1;
        r.opcode = cur_op;
        case (cur_op)
            ftmd_pkg::OP_RRQ, ftmd_pkg::OP_WRQ, ftmd_pkg::OP_LOGIN, ftmd_pkg::OP_MSG:
                return string_byte(b, r);
            ftmd_pkg::OP_DATA:
            begin
                if (n == 0 || n == 2)
                begin
                    hold_byte = b;
                    return 1'b0;
                end
                r.kind = ftmd_pkg::KIND_HEADER;
                if (n == 1)
                begin
                    size_word = {hold_byte, b};
                    r.value = size_word;
                end
                else if (n == 3)
                begin
                    r.slot = 1'b1;
                    r.value = {hold_byte, b};
                    if (size_word == 16'h0)
                    begin
                        end_msg();
                        r.last = 1'b1;
                    end
                end
                else
                begin
                    r.kind = ftmd_pkg::KIND_PAYLOAD;
                    r.value = {8'h00, b};
                    if ((n - 17'd3) >= {1'b0, size_word})
                    begin
                        end_msg();
                        r.last = 1'b1;
                    end
                end
                return 1'b1;
            end
            ftmd_pkg::OP_ACK:
            begin
                if (n == 0)
                begin
                    hold_byte = b;
                    return 1'b0;
                end
                end_msg();
                r.kind = ftmd_pkg::KIND_HEADER;
                r.value = {hold_byte, b};
                r.last = 1'b1;
                return 1'b1;
            end
            ftmd_pkg::OP_ERROR:
            begin
                if (n == 0)
                begin
                    hold_byte = b;
                    return 1'b0;
                end
                if (n == 1)
                begin
                    r.kind = ftmd_pkg::KIND_HEADER;
                    r.value = {hold_byte, b};
                    return 1'b1;
                end
                return string_byte(b, r);
            end
            ftmd_pkg::OP_BCAST:
            begin
                if (n == 0)
                begin
                    r.kind = ftmd_pkg::KIND_FLAG;
                    r.value = {8'h00, b};
                    return 1'b1;
                end
                return string_byte(b, r);
            end
            default:
            begin
                end_msg();
                return 1'b0;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        frame_item_t got;
        bit          has;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.byte_in <= b;
        do @(posedge clk); while (!byte_if.ready);
        bytes_sent++;
        has = deframe_byte(b, got);
        if (has)
            pending_frames = {pending_frames, got};
    endtask

    task automatic send_word(input logic [15:0] w);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
    endtask

    task automatic send_string(input int len);
        logic [7:0] b;
        repeat (len)
        begin
            do b = 8'($urandom); while (b == term_byte);
            send_byte(b);
        end
        send_byte(term_byte);
    endtask

    task automatic send_message(input logic [3:0] op, input int len);
        send_word({12'h000, op});
        case (op)
            ftmd_pkg::OP_RRQ, ftmd_pkg::OP_WRQ, ftmd_pkg::OP_LOGIN, ftmd_pkg::OP_MSG:
                send_string(len);
            ftmd_pkg::OP_DATA:
            begin
                send_word(len[15:0]);
                send_word(16'($urandom));
                repeat (len) send_byte(8'($urandom));
            end
            ftmd_pkg::OP_ACK:
                send_word(16'($urandom));
            ftmd_pkg::OP_ERROR:
            begin
                send_word(16'($urandom));
                send_string(len);
            end
            ftmd_pkg::OP_BCAST:
            begin
                send_byte(8'($urandom));
                send_string(len);
            end
            default:
                ;
        endcase
    endtask

    function automatic int pick_len();
        return ($urandom_range(99) < 90) ? $urandom_range(0, 12) : $urandom_range(13, 300);
    endfunction

    // sender holds off until every result is in and the pipe is empty
    task automatic settle();
        byte_if.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_terminator(input logic [7:0] t);
        settle();
        cfg_if.valid <= 1'b1;
        cfg_if.terminator_byte <= t;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        term_byte = t;
        term_writes++;
    endtask

    task automatic test_every_opcode();
        for (int op = 1; op <= 10; op++)
            send_message(op[3:0], 3);
    endtask

    task automatic test_bad_opcodes();
        send_word(16'h0000);
        send_word(16'h000B);
        send_word(16'h000F);
        send_word(16'h0100);
        send_word(16'hFFFF);
    endtask

    task automatic test_header_extremes();
        // empty DATA ends on the block word
        send_word(16'(ftmd_pkg::OP_DATA));
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'(ftmd_pkg::OP_DATA));
        send_word(16'h0002);
        send_word(16'h0000);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_word(16'(ftmd_pkg::OP_ACK));
        send_word(16'h0000);
        send_word(16'(ftmd_pkg::OP_ACK));
        send_word(16'hFFFF);
        // code and flag bytes equal to the terminator are data
        for (int pass = 0; pass < 2; pass++)
        begin
            send_word(16'(ftmd_pkg::OP_ERROR));
            send_word({term_byte, term_byte});
            send_string(1);
            send_word(16'(ftmd_pkg::OP_BCAST));
            send_byte(term_byte);
            send_string(0);
            if (pass == 0)
                write_terminator(8'hFF);
        end
        send_word(16'(ftmd_pkg::OP_RRQ));
        send_byte(8'h00);
        send_byte(term_byte);
        send_message(ftmd_pkg::OP_LOGIN, 4);
        send_message(ftmd_pkg::OP_MSG, 0);
    endtask

    task automatic test_backpressure();
        write_terminator(8'h00);
        hold_off_request = 300;
        send_message(ftmd_pkg::OP_DATA, 80);
        settle();
    endtask

    task automatic test_long_messages();
        send_idle_pct = 0;
        take_idle_pct = 0;
        send_message(ftmd_pkg::OP_DATA, 200);
        send_message(ftmd_pkg::OP_BCAST, 100);
        settle();
        send_idle_pct = 28;
        take_idle_pct = 28;
    endtask

    task automatic test_random_traffic();
        int          start;
        int          last_cfg;
        int          done;
        int          pick;
        logic [15:0] word;
        start = bytes_sent;
        last_cfg = bytes_sent;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            if (bytes_sent - last_cfg >= 250)
            begin
                case ($urandom_range(3))
                    0: write_terminator(8'h00);
                    1: write_terminator(8'hFF);
                    default: write_terminator(8'($urandom));
                endcase
                last_cfg = bytes_sent;
            end
            if (done >= 250 && done < 400)
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = 28;
                take_idle_pct = 28;
            end
            pick = $urandom_range(99);
            if (pick < 80)
                send_message(4'($urandom_range(1, 10)), pick_len());
            else if (pick < 88)
            begin
                word = 16'($urandom);
                if (word >= 16'd1 && word <= 16'(ftmd_pkg::OP_DISC))
                    word[15:8] = 8'($urandom_range(1, 255));
                send_word(word);
            end
            else if (pick < 94)
            begin
                send_word(16'($urandom_range(1, 10)));
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            end
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            done = bytes_sent - start;
        end
        send_idle_pct = 28;
        take_idle_pct = 28;
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request > 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
                res_if.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        frame_item_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (pending_frames.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none", $time);
                $display("%0t:   actual op %0d kind %0d slot %0d value %h last %0d",
                         $time, res_if.msg_opcode, res_if.item_kind, res_if.field_slot,
                         res_if.value, res_if.last);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (res_if.msg_opcode !== want.opcode || res_if.item_kind !== want.kind ||
                    res_if.field_slot !== want.slot || res_if.value !== want.value ||
                    res_if.last !== want.last)
                begin
                    errors++;
                    $display("%0t: mismatch, expected op %0d kind %0d slot %0d value %h last %0d",
                             $time, want.opcode, want.kind, want.slot, want.value, want.last);
                    $display("%0t:           actual op %0d kind %0d slot %0d value %h last %0d",
                             $time, res_if.msg_opcode, res_if.item_kind, res_if.field_slot,
                             res_if.value, res_if.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_frames.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        byte_if.valid <= 1'b0;
        byte_if.byte_in <= 8'h00;
        res_if.ready <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.terminator_byte <= 8'h00;
        ph = ftmd_pkg::PH_HIGH;
        hold_byte = 8'h00;
        cur_op = ftmd_pkg::OP_NONE;
        body_cnt = '0;
        size_word = 16'h0;
        term_byte = 8'h00;
        send_idle_pct = 28;
        take_idle_pct = 28;
        hold_off_request = 0;
        bytes_sent = 0;
        results_seen = 0;
        term_writes = 0;
        errors = 0;
        cycle_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_every_opcode();
        test_bad_opcodes();
        test_header_extremes();
        test_backpressure();
        test_long_messages();
        test_random_traffic();
        settle();

        $display("Sent %0d bytes, checked %0d results over %0d terminator settings.",
                 bytes_sent, results_seen, term_writes + 1);
        $display("All opcodes, bad opcodes, header edge cases, long bodies, output hold-off.");
        if (errors == 0 && pending_frames.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
